// ===== rtl/pwq_pkg.sv =====
// pwq_pkg: shared types, widths and codes of the priority wait queue wake unit
// no dependencies; used by pwq_seq and priority_wait_queue_wake_unit
package pwq_pkg;

  // queue geometry
  localparam int QueueDepth = 64;
  localparam int IdxW       = $clog2(QueueDepth);
  localparam int CntW       = $clog2(QueueDepth + 1);

  // field widths
  localparam int TidW    = 8;
  localparam int PrioW   = 8;
  localparam int KeyW    = 32;
  localparam int StatusW = 2;

  // command codes
  localparam logic CmdInsert = 1'b0;
  localparam logic CmdWake   = 1'b1;

  // result status codes
  localparam logic [StatusW-1:0] StOk      = 2'd0;
  localparam logic [StatusW-1:0] StNoMatch = 2'd1;
  localparam logic [StatusW-1:0] StFull    = 2'd2;

  // one queue entry
  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [PrioW-1:0] prio;
    logic [TidW-1:0]  tid;
  } pwq_entry_t;

  localparam int EntryW = $bits(pwq_entry_t);

  // request handed to the sequencer
  typedef struct packed {
    logic             cmd;
    logic             from_cursor;
    logic [TidW-1:0]  tid;
    logic [PrioW-1:0] prio;
    logic [KeyW-1:0]  key;
  } pwq_req_t;

  // result handed back by the sequencer
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [TidW-1:0]    tid;
  } pwq_res_t;

  // entry memory access from the sequencer
  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    pwq_entry_t      wdata;
    logic [IdxW-1:0] raddr;
  } pwq_ram_cmd_t;

endpackage

// ===== rtl/priority_wait_queue_wake_unit.sv =====
// An insert into an empty or full queue or a wake of an empty one is answered without a walk;
// else an insert moves up each worse-priority entry that it passes, and a wake scans rank by
// rank from the head or the cursor and then closes up the entries behind the hit.
// One item at a time, set by the rank-by-rank walk of the entry ram; tready returns the cycle
// after the result moves to the output register, where it may wait while a new item runs.
// Reset clears count, cursor and handshake state; entries stay undefined. Uses pwq_pkg/seq/ram.
module priority_wait_queue_wake_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // thread_id[7:0], priority_req[15:8], wait_key[47:16]
  input  logic [1:0]  s_axis_tuser,  // command[0], from_cursor[1]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // status[1:0], woken_thread[9:2], zero[15:10]
);

  pwq_pkg::pwq_req_t     req;
  pwq_pkg::pwq_res_t     res;
  pwq_pkg::pwq_ram_cmd_t ram_cmd;
  pwq_pkg::pwq_entry_t   rdata;
  logic [pwq_pkg::EntryW-1:0] rdata_raw;
  logic                  res_valid, res_taken;
  logic                  out_valid_q, out_valid_d;
  pwq_pkg::pwq_res_t     out_q;

  // unpack input transfer
  assign req.cmd         = s_axis_tuser[0];
  assign req.from_cursor = s_axis_tuser[1];
  assign req.tid         = s_axis_tdata[7:0];
  assign req.prio        = s_axis_tdata[15:8];
  assign req.key         = s_axis_tdata[47:16];

  pwq_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_i       (req),
    .req_ready_o (s_axis_tready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_taken_i (res_taken),
    .ram_o       (ram_cmd),
    .rdata_i     (rdata)
  );

  pwq_ram #(
    .Width (pwq_pkg::EntryW),
    .Depth (pwq_pkg::QueueDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_cmd.we),
    .waddr_i (ram_cmd.waddr),
    .wdata_i (ram_cmd.wdata),
    .raddr_i (ram_cmd.raddr),
    .rdata_o (rdata_raw)
  );

  assign rdata = rdata_raw;

  // output register
  assign res_taken   = res_valid && (!out_valid_q || m_axis_tready);
  assign out_valid_d = res_taken || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_taken) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_q.tid, out_q.status};

endmodule

// ===== rtl/pwq_ram.sv =====
// pwq_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module pwq_ram #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pwq_seq.sv =====
// pwq_seq: sequencer that walks the entry memory one rank a cycle for insert and wake
// depends on pwq_pkg; drives the entry ram through a pwq_ram_cmd_t
module pwq_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  input  pwq_pkg::pwq_req_t     req_i,
  output logic                  req_ready_o,
  output logic                  res_valid_o,
  output pwq_pkg::pwq_res_t     res_o,
  input  logic                  res_taken_i,
  output pwq_pkg::pwq_ram_cmd_t ram_o,
  input  pwq_pkg::pwq_entry_t   rdata_i
);

  localparam logic [2:0] SIdle    = 3'd0;
  localparam logic [2:0] SIns     = 3'd1;
  localparam logic [2:0] SInsLast = 3'd2;
  localparam logic [2:0] SScan    = 3'd3;
  localparam logic [2:0] SShift   = 3'd4;
  localparam logic [2:0] SDone    = 3'd5;

  localparam int CntW = pwq_pkg::CntW;
  localparam int IdxW = pwq_pkg::IdxW;

  logic [2:0]        state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   cur_q, cur_d;
  logic [CntW-1:0]   pos_q, pos_d;
  pwq_pkg::pwq_req_t req_q, req_d;
  pwq_pkg::pwq_res_t res_q, res_d;

  logic [CntW-1:0]   pos_m1, pos_m2, cnt_m1, start;
  logic [CntW:0]     pos_p1, pos_p2, cnt_w;
  pwq_pkg::pwq_entry_t new_entry, in_entry;

  // neighbour ranks and new entries
  assign pos_m1 = pos_q - CntW'(1);
  assign pos_m2 = pos_q - CntW'(2);
  assign cnt_m1 = cnt_q - CntW'(1);
  assign pos_p1 = {1'b0, pos_q} + (CntW+1)'(1);
  assign pos_p2 = {1'b0, pos_q} + (CntW+1)'(2);
  assign cnt_w  = {1'b0, cnt_q};
  assign start  = (req_i.from_cursor && (cur_q < cnt_q)) ? cur_q : '0;

  assign new_entry.tid  = req_q.tid;
  assign new_entry.prio = req_q.prio;
  assign new_entry.key  = req_q.key;
  assign in_entry.tid   = req_i.tid;
  assign in_entry.prio  = req_i.prio;
  assign in_entry.key   = req_i.key;

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    pos_d       = pos_q;
    req_d       = req_q;
    res_d       = res_q;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    ram_o.we    = 1'b0;
    ram_o.waddr = pos_q[IdxW-1:0];
    ram_o.wdata = new_entry;
    ram_o.raddr = '0;
    case (state_q)
      SIdle: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          req_d      = req_i;
          res_d.tid  = '0;
          res_d.status = pwq_pkg::StOk;
          if (req_i.cmd == pwq_pkg::CmdInsert) begin
            if (cnt_q >= CntW'(pwq_pkg::QueueDepth)) begin
              res_d.status = pwq_pkg::StFull;
              state_d      = SDone;
            end else if (cnt_q == '0) begin
              ram_o.we    = 1'b1;
              ram_o.waddr = '0;
              ram_o.wdata = in_entry;
              cnt_d       = CntW'(1);
              state_d     = SDone;
            end else begin
              pos_d       = cnt_q;
              ram_o.raddr = cnt_m1[IdxW-1:0];
              state_d     = SIns;
            end
          end else begin
            if (cnt_q == '0) begin
              res_d.status = pwq_pkg::StNoMatch;
              state_d      = SDone;
            end else begin
              pos_d       = start;
              ram_o.raddr = start[IdxW-1:0];
              state_d     = SScan;
            end
          end
        end
      end
      SIns: begin
        // entry at pos-1 is in the read register
        ram_o.we = 1'b1;
        if (req_q.prio < rdata_i.prio) begin
          ram_o.wdata = rdata_i;
          pos_d       = pos_m1;
          if (pos_m1 == '0) begin
            state_d = SInsLast;
          end else begin
            ram_o.raddr = pos_m2[IdxW-1:0];
          end
        end else begin
          cnt_d   = cnt_q + CntW'(1);
          state_d = SDone;
        end
      end
      SInsLast: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = '0;
        cnt_d       = cnt_q + CntW'(1);
        state_d     = SDone;
      end
      SScan: begin
        // entry at pos is in the read register
        if (rdata_i.key == req_q.key) begin
          res_d.tid = rdata_i.tid;
          if (pos_p1 < cnt_w) begin
            cur_d       = pos_q;
            ram_o.raddr = pos_p1[IdxW-1:0];
            state_d     = SShift;
          end else begin
            cur_d   = '0;
            cnt_d   = cnt_m1;
            state_d = SDone;
          end
        end else if (pos_p1 < cnt_w) begin
          pos_d       = pos_p1[CntW-1:0];
          ram_o.raddr = pos_p1[IdxW-1:0];
        end else begin
          res_d.status = pwq_pkg::StNoMatch;
          state_d      = SDone;
        end
      end
      SShift: begin
        // close up: entry at pos+1 moves to pos
        ram_o.we    = 1'b1;
        ram_o.wdata = rdata_i;
        pos_d       = pos_p1[CntW-1:0];
        if (pos_p2 < cnt_w) begin
          ram_o.raddr = pos_p2[IdxW-1:0];
        end else begin
          cnt_d   = cnt_m1;
          state_d = SDone;
        end
      end
      SDone: begin
        res_valid_o = 1'b1;
        if (res_taken_i) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  assign res_o = res_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q   <= '0;
      cur_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      cur_q   <= cur_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    req_q <= req_d;
    res_q <= res_d;
  end

endmodule

// ===== verif/priority_wait_queue_wake_unit_tb.sv =====
// priority_wait_queue_wake_unit_tb: self-checking bench for the priority wait queue wake unit
// streams insert and wake commands with random gaps and back-pressure against a shadow queue
// depends on pwq_pkg and the priority_wait_queue_wake_unit rtl
module priority_wait_queue_wake_unit_tb;

  localparam int unsigned TimeoutCycles = 1_500_000;
  localparam int          RandomItems   = 1000;
  localparam int          DrainCycles   = 2 * pwq_pkg::QueueDepth + 8;

  // one queued command with its lead-in gap and hold-off flag
  typedef struct {
    pwq_pkg::pwq_req_t req;
    int unsigned       gap;
    bit                drain;
  } queue_cmd_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // thread_id[7:0], priority_req[15:8], wait_key[47:16]
  logic [1:0]  s_axis_tuser = '0;  // command[0], from_cursor[1]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;       // status[1:0], woken_thread[9:2], zero[15:10]

  // commands not yet driven and results not yet seen
  queue_cmd_t          pending_cmds[$];
  pwq_pkg::pwq_res_t   results_due[$];

  // shadow copy of the sorted wait queue
  pwq_pkg::pwq_entry_t shadow_q[pwq_pkg::QueueDepth];
  int                  shadow_count = 0;
  int                  shadow_cursor = 0;

  int unsigned in_xfers = 0;
  int unsigned items_issued = 0;
  int unsigned error_count = 0;
  logic [pwq_pkg::KeyW-1:0] key_pool[8];

  // driver private state
  queue_cmd_t  staged_cmd;
  bit          staged = 1'b0;
  int unsigned gap_left = 0;

  // sink side stall state
  int unsigned stall_left = 0;
  int unsigned sink_calm = 0;

  priority_wait_queue_wake_unit DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  always #5 clk = ~clk;

  // idle length: mostly short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    $display("mismatch %0d: %s", error_count, what);
  endtask

  // stable priority insert and keyed wake on the shadow queue
  task automatic apply_queue_cmd(input pwq_pkg::pwq_req_t c, output pwq_pkg::pwq_res_t res);
    int at;
    int hit;
    int i;
    res.status = pwq_pkg::StOk;
    res.tid    = '0;
    if (c.cmd == pwq_pkg::CmdInsert) begin
      if (shadow_count >= pwq_pkg::QueueDepth) begin
        res.status = pwq_pkg::StFull;
      end else begin
        at = shadow_count;
        while (at > 0 && c.prio < shadow_q[at-1].prio) begin
          shadow_q[at] = shadow_q[at-1];
          at--;
        end
        shadow_q[at] = '{key: c.key, prio: c.prio, tid: c.tid};
        shadow_count++;
      end
    end else begin
      // cursor at or past the count falls back to the head
      hit = (c.from_cursor && shadow_cursor < shadow_count) ? shadow_cursor : 0;
      while (hit < shadow_count && shadow_q[hit].key != c.key) hit++;
      if (hit >= shadow_count) begin
        res.status = pwq_pkg::StNoMatch;
      end else begin
        res.tid = shadow_q[hit].tid;
        for (i = hit; i + 1 < shadow_count; i++) shadow_q[i] = shadow_q[i+1];
        shadow_cursor = (hit + 1 < shadow_count) ? hit : 0;
        shadow_count--;
      end
    end
  endtask

  function automatic queue_cmd_t make_cmd(input logic cmd, input logic cur, input int tid,
                                          input int prio,
                                          input logic [pwq_pkg::KeyW-1:0] key);
    queue_cmd_t q;
    q.req.cmd         = cmd;
    q.req.from_cursor = cur;
    q.req.tid         = tid[pwq_pkg::TidW-1:0];
    q.req.prio        = prio[pwq_pkg::PrioW-1:0];
    q.req.key         = key;
    q.gap             = 0;
    q.drain           = 1'b0;
    return q;
  endfunction

  // source driver: one transfer held until taken, gaps between items
  always @(negedge clk) begin
    if (rst_n && !(s_axis_tvalid && in_xfers != items_issued)) begin
      if (!staged && pending_cmds.size() != 0) begin
        staged_cmd = pending_cmds.pop_front();
        staged     = 1'b1;
        gap_left   = staged_cmd.gap;
      end
      if (staged && gap_left == 0 && !(staged_cmd.drain && results_due.size() != 0)) begin
        s_axis_tdata  <= {staged_cmd.req.key, staged_cmd.req.prio, staged_cmd.req.tid};
        s_axis_tuser  <= {staged_cmd.req.from_cursor, staged_cmd.req.cmd};
        s_axis_tvalid <= 1'b1;
        items_issued  <= items_issued + 1;
        staged = 1'b0;
      end else begin
        s_axis_tvalid <= 1'b0;
        if (staged && gap_left != 0) gap_left--;
      end
    end
  end

  // sink back-pressure with calm windows
  always @(negedge clk) begin
    if (!rst_n) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      if (sink_calm != 0) begin
        sink_calm--;
      end else if ($urandom_range(0, 99) < 3) begin
        sink_calm = $urandom_range(50, 200);
      end else if ($urandom_range(0, 99) < 35) begin
        stall_left = pick_gap();
      end
    end
  end

  // monitor: predict on input transfer, check on output transfer
  always @(posedge clk) begin
    pwq_pkg::pwq_req_t req;
    pwq_pkg::pwq_res_t res;
    pwq_pkg::pwq_res_t want;
    if (rst_n) begin
      if (s_axis_tvalid && s_axis_tready) begin
        req.cmd         = s_axis_tuser[0];
        req.from_cursor = s_axis_tuser[1];
        req.tid         = s_axis_tdata[7:0];
        req.prio        = s_axis_tdata[15:8];
        req.key         = s_axis_tdata[47:16];
        apply_queue_cmd(req, res);
        results_due.push_back(res);
        in_xfers <= in_xfers + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("result 0x%04h with none outstanding", m_axis_tdata));
        end else begin
          want = results_due.pop_front();
          if (m_axis_tdata[1:0] != want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      m_axis_tdata[1:0], want.status));
          if (m_axis_tdata[9:2] != want.tid)
            report_mismatch($sformatf("woken_thread got 0x%02h want 0x%02h",
                                      m_axis_tdata[9:2], want.tid));
        end
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    queue_cmd_t  q;
    int          n_rand;
    int          phase_len;
    int          insert_pct;
    bit          calm;
    int          k;
    logic        cmd_pick;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (k = 2; k < 8; k++) key_pool[k] = $urandom;

    // directed: empty wakes, extremes, ties, cursor walk, no wrap, last removal
    pending_cmds.push_back(make_cmd(pwq_pkg::CmdWake,   1'b0, 8'h00, 8'h00, 32'h0000_0000));
    pending_cmds.push_back(make_cmd(pwq_pkg::CmdWake,   1'b1, 8'hff, 8'hff, 32'h0000_0000));
    pending_cmds.push_back(make_cmd(pwq_pkg::CmdInsert, 1'b0, 8'h00, 8'hff, 32'h0000_0000));
    pending_cmds.push_back(make_cmd(pwq_pkg::CmdInsert, 1'b1, 8'hff, 8'h00, 32'hffff_ffff));
    pending_cmds.push_back(make_cmd(pwq_pkg::CmdInsert, 1'b0, 8'h5a, 8'h00, 32'h0000_0000));
    pending_cmds.push_back(make_cmd(pwq_pkg::CmdInsert, 1'b1, 8'ha5, 8'h80, 32'ha5a5_a5a5));
    pending_cmds.push_back(make_cmd(pwq_pkg::CmdInsert, 1'b0, 8'h3c, 8'hff, 32'h5a5a_5a5a));
    pending_cmds.push_back(make_cmd(pwq_pkg::CmdWake,   1'b0, 8'hff, 8'hff, 32'h0000_0000));
    pending_cmds.push_back(make_cmd(pwq_pkg::CmdWake,   1'b1, 8'h00, 8'h00, 32'h0000_0000));
    pending_cmds.push_back(make_cmd(pwq_pkg::CmdWake,   1'b1, 8'h00, 8'h00, 32'hffff_ffff));
    pending_cmds.push_back(make_cmd(pwq_pkg::CmdWake,   1'b1, 8'h00, 8'h00, 32'h5a5a_5a5a));
    pending_cmds.push_back(make_cmd(pwq_pkg::CmdWake,   1'b1, 8'h00, 8'h00, 32'hffff_ffff));
    pending_cmds.push_back(make_cmd(pwq_pkg::CmdWake,   1'b0, 8'h00, 8'h00, 32'ha5a5_a5a5));
    pending_cmds.push_back(make_cmd(pwq_pkg::CmdWake,   1'b0, 8'h00, 8'h00, 32'h1234_5678));

    // random phases with varying insert share, the first one insert-heavy
    n_rand     = 0;
    insert_pct = 90;
    while (n_rand < RandomItems) begin
      phase_len = $urandom_range(60, 150);
      calm      = ($urandom_range(0, 3) == 0);
      for (k = 0; k < phase_len; k++) begin
        cmd_pick = ($urandom_range(0, 99) < insert_pct) ? pwq_pkg::CmdInsert
                                                         : pwq_pkg::CmdWake;
        q = make_cmd(cmd_pick,
                     1'($urandom_range(0, 1)), $urandom_range(0, 255),
                     ($urandom_range(0, 1) != 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(0, 3) * 85,
                     ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, 7)]
                                                  : $urandom);
        q.gap   = (calm || $urandom_range(0, 1) != 0) ? 0 : pick_gap();
        q.drain = (k == 0);
        pending_cmds.push_back(q);
      end
      n_rand += phase_len;
      case ($urandom_range(0, 2))
        0: insert_pct = 90;
        1: insert_pct = 55;
        default: insert_pct = 20;
      endcase
    end

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || staged || in_xfers != items_issued ||
           results_due.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // watchdog
  initial begin
    #(TimeoutCycles * 10);
    $display("Regression FAIL");
    $finish;
  end

endmodule
